// File: rtl/plet_pkg.sv
// Shared constants and types for the priority LRU eviction table.
`default_nettype none
package plet_pkg;
   localparam int ENTRIES = 32;
   localparam int PLACES  = 4;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int PL_W    = $clog2(PLACES);
   localparam int STAMP_W = 48;
   localparam int SUM_W   = 45;
   localparam logic [STAMP_W-1:0] STAMP_TOP = '1;
   localparam logic [2:0] RANK_TOP = 3'd4;

   localparam logic [2:0] ACT_ADD    = 3'd0;
   localparam logic [2:0] ACT_REMOVE = 3'd1;
   localparam logic [2:0] ACT_TOUCH  = 3'd2;
   localparam logic [2:0] ACT_RANK   = 3'd3;
   localparam logic [2:0] ACT_PLACE  = 3'd4;
   localparam logic [2:0] ACT_SEL1   = 3'd5;
   localparam logic [2:0] ACT_SELSZ  = 3'd6;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_ABSENT = 2'd1;
   localparam logic [1:0] STAT_FULL   = 2'd2;

   typedef struct packed {
      logic [2:0]         rank;
      logic [STAMP_W-1:0] stamp;
   } order_type;
endpackage
`default_nettype wire

// File: rtl/plet_rank_cmp.sv
// Eviction order compare: is the candidate evicted before the current best.
`default_nettype none
module plet_rank_cmp
   import plet_pkg::*;
(
   input  wire logic      best_valid,
   input  wire order_type cand,
   input  wire order_type best,
   output logic           better
);
   always_comb begin
      better = !best_valid || (cand.rank > best.rank) ||
               ((cand.rank == best.rank) && (cand.stamp < best.stamp));
   end
endmodule
`default_nettype wire

// File: rtl/priority_lru_eviction_table_top.sv
// Priority LRU eviction table: slot store, running sums and scan sequencer.
// Add/remove/touch/set scan all slots (one slot lookup per cycle), then update.
// Select one scans all slots once; select for size scans all slots once per victim.
// A new request is taken once the last response of the previous one has shown.
// Responses cannot be stalled; each is a one-cycle rsp_valid pulse.
// Reset empties the table and clears the stamp counter and sums.
`default_nettype none
module priority_lru_eviction_table_top
   import plet_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_action,
   input  wire logic [63:0] req_entry_id,
   input  wire logic [2:0]  req_entry_rank,
   input  wire logic [39:0] req_entry_bytes,
   input  wire logic [1:0]  req_entry_place,
   input  wire logic [45:0] req_bytes_needed,
   output logic             rsp_valid,
   output logic             rsp_victim_found,
   output logic [63:0]      rsp_victim_id,
   output logic [39:0]      rsp_victim_bytes,
   output logic [1:0]       rsp_victim_place,
   output logic [2:0]       rsp_victim_rank,
   output logic             rsp_last_result,
   output logic [1:0]       rsp_status,
   output logic [5:0]       rsp_entry_count,
   output logic [44:0]      rsp_total_bytes,
   output logic [44:0]      rsp_place_bytes
);
   typedef enum logic [2:0] {ST_IDLE, ST_FIND, ST_SUB, ST_ADD, ST_DONE, ST_SEARCH} state_type;

   state_type state_ff;
   logic [IDX_W-1:0] idx_ff;

   logic [ENTRIES-1:0] valid_ff;
   logic [63:0]        key_ff   [ENTRIES];
   logic [2:0]         rank_ff  [ENTRIES];
   logic [39:0]        bytes_ff [ENTRIES];
   logic [1:0]         place_ff [ENTRIES];
   logic [STAMP_W-1:0] stamp_ff [ENTRIES];
   logic [STAMP_W-1:0] counter_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [SUM_W-1:0]   total_ff;
   logic [SUM_W-1:0]   psum_ff [PLACES];

   logic [2:0]  act_ff;
   logic [63:0] id_ff;
   logic [2:0]  rq_rank_ff;
   logic [39:0] rq_bytes_ff;
   logic [1:0]  rq_place_ff;
   logic [45:0] need_ff;
   logic [1:0]  status_ff;

   logic             match_ff, free_ff, matched_ff, tgt_ok_ff;
   logic [IDX_W-1:0] match_idx_ff, free_idx_ff;

   logic               best_ok_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   logic [2:0]         best_rank_ff;
   logic [STAMP_W-1:0] best_stamp_ff;
   logic [63:0]        best_key_ff;
   logic [39:0]        best_bytes_ff;
   logic [1:0]         best_place_ff;
   logic [ENTRIES-1:0] done_ff;
   logic [CNT_W-1:0]   n_ff, cand_ff;
   logic [46:0]        sum_ff;

   logic             cur_valid, cur_match, cur_elig, better, last_idx, take;
   logic [1:0]       cur_place;
   logic [PL_W-1:0]  psel;
   logic [SUM_W-1:0] ps_cur;
   logic [STAMP_W-1:0] stamp_nx;
   logic             m_now, f_now;
   logic [IDX_W-1:0] mi_now, fi_now;
   logic             fb_ok;
   logic [IDX_W-1:0] fb_idx;
   logic [2:0]       fb_rank;
   logic [63:0]      fb_key;
   logic [39:0]      fb_bytes;
   logic [1:0]       fb_place;
   logic [CNT_W-1:0] cand_tot, n_nx;
   logic [46:0]      sum_nx;
   logic             fin;
   order_type        cand_o, best_o;

   assign busy      = (state_ff != ST_IDLE);
   assign cur_valid = valid_ff[idx_ff];
   assign cur_place = place_ff[idx_ff];
   assign cur_match = cur_valid && (key_ff[idx_ff] == id_ff);
   assign cur_elig  = cur_valid && (rank_ff[idx_ff] != 3'd0) && (cur_place == rq_place_ff) &&
                      !done_ff[idx_ff];
   assign last_idx  = (idx_ff == IDX_W'(ENTRIES - 1));
   assign psel      = (state_ff == ST_SUB) ? PL_W'(cur_place) : PL_W'(rq_place_ff);
   assign ps_cur    = psum_ff[psel];
   assign stamp_nx  = (counter_ff == STAMP_TOP) ? STAMP_TOP : counter_ff + 1'b1;

   assign cand_o = '{rank: rank_ff[idx_ff], stamp: stamp_ff[idx_ff]};
   assign best_o = '{rank: best_rank_ff, stamp: best_stamp_ff};

   plet_rank_cmp u_cmp (
      .best_valid (best_ok_ff),
      .cand       (cand_o),
      .best       (best_o),
      .better     (better)
   );

   always_comb begin
      take     = cur_elig && better;
      m_now    = match_ff || cur_match;
      mi_now   = match_ff ? match_idx_ff : idx_ff;
      f_now    = free_ff || !cur_valid;
      fi_now   = free_ff ? free_idx_ff : idx_ff;
      fb_ok    = best_ok_ff || take;
      fb_idx   = take ? idx_ff : best_idx_ff;
      fb_rank  = take ? rank_ff[idx_ff] : best_rank_ff;
      fb_key   = take ? key_ff[idx_ff] : best_key_ff;
      fb_bytes = take ? bytes_ff[idx_ff] : best_bytes_ff;
      fb_place = take ? cur_place : best_place_ff;
      cand_tot = cand_ff + CNT_W'(cur_elig && (n_ff == '0));
      n_nx     = n_ff + 1'b1;
      sum_nx   = sum_ff + 47'(fb_bytes);
      fin      = !fb_ok || (act_ff == ACT_SEL1) || (sum_nx >= {1'b0, need_ff}) ||
                 (n_nx == CNT_W'(ENTRIES)) || (n_nx == cand_tot);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '0;
         counter_ff <= '0;
         count_ff   <= '0;
         total_ff   <= '0;
         for (int p = 0; p < PLACES; p++) psum_ff[p] <= '0;
         rsp_valid  <= 1'b0;
      end else begin
         rsp_valid <= (state_ff == ST_DONE) || ((state_ff == ST_SEARCH) && last_idx);
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  act_ff      <= req_action;
                  id_ff       <= req_entry_id;
                  rq_rank_ff  <= (req_entry_rank > RANK_TOP) ? RANK_TOP : req_entry_rank;
                  rq_bytes_ff <= req_entry_bytes;
                  rq_place_ff <= (32'(req_entry_place) >= PLACES) ? 2'(PLACES - 1)
                                                                 : req_entry_place;
                  need_ff     <= req_bytes_needed;
                  status_ff   <= STAT_OK;
                  idx_ff      <= '0;
                  match_ff    <= 1'b0;
                  free_ff     <= 1'b0;
                  best_ok_ff  <= 1'b0;
                  done_ff     <= '0;
                  n_ff        <= '0;
                  cand_ff     <= '0;
                  sum_ff      <= '0;
                  priority if (req_action == ACT_SEL1) begin
                     state_ff <= ST_SEARCH;
                  end else if (req_action == ACT_SELSZ) begin
                     state_ff <= (req_bytes_needed == '0) ? ST_DONE : ST_SEARCH;
                  end else if (req_action > ACT_SELSZ) begin
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_FIND;
                  end
               end
            end
            ST_FIND: begin
               if (cur_match && !match_ff) begin
                  match_ff     <= 1'b1;
                  match_idx_ff <= idx_ff;
               end
               if (!cur_valid && !free_ff) begin
                  free_ff     <= 1'b1;
                  free_idx_ff <= idx_ff;
               end
               if (last_idx) begin
                  idx_ff     <= m_now ? mi_now : fi_now;
                  matched_ff <= m_now;
                  tgt_ok_ff  <= m_now || f_now;
                  state_ff   <= ST_SUB;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_SUB: begin
               if (matched_ff && ((act_ff == ACT_ADD) || (act_ff == ACT_REMOVE) ||
                                  (act_ff == ACT_PLACE))) begin
                  total_ff      <= total_ff - SUM_W'(bytes_ff[idx_ff]);
                  psum_ff[psel] <= ps_cur - SUM_W'(bytes_ff[idx_ff]);
               end
               if (matched_ff && (act_ff == ACT_REMOVE)) begin
                  valid_ff[idx_ff] <= 1'b0;
                  count_ff         <= count_ff - 1'b1;
               end
               state_ff <= ST_ADD;
            end
            ST_ADD: begin
               state_ff <= ST_DONE;
               unique case (act_ff)
                  ACT_ADD: begin
                     if (!tgt_ok_ff) begin
                        status_ff <= STAT_FULL;
                     end else begin
                        valid_ff[idx_ff] <= 1'b1;
                        key_ff[idx_ff]   <= id_ff;
                        rank_ff[idx_ff]  <= rq_rank_ff;
                        bytes_ff[idx_ff] <= rq_bytes_ff;
                        place_ff[idx_ff] <= rq_place_ff;
                        stamp_ff[idx_ff] <= stamp_nx;
                        counter_ff       <= stamp_nx;
                        total_ff         <= total_ff + SUM_W'(rq_bytes_ff);
                        psum_ff[psel]    <= ps_cur + SUM_W'(rq_bytes_ff);
                        if (!matched_ff) count_ff <= count_ff + 1'b1;
                     end
                  end
                  ACT_TOUCH: begin
                     if (!matched_ff) begin
                        status_ff <= STAT_ABSENT;
                     end else begin
                        stamp_ff[idx_ff] <= stamp_nx;
                        counter_ff       <= stamp_nx;
                     end
                  end
                  ACT_RANK: begin
                     if (!matched_ff) status_ff <= STAT_ABSENT;
                     else rank_ff[idx_ff] <= rq_rank_ff;
                  end
                  ACT_PLACE: begin
                     if (!matched_ff) begin
                        status_ff <= STAT_ABSENT;
                     end else begin
                        place_ff[idx_ff] <= rq_place_ff;
                        total_ff         <= total_ff + SUM_W'(bytes_ff[idx_ff]);
                        psum_ff[psel]    <= ps_cur + SUM_W'(bytes_ff[idx_ff]);
                     end
                  end
                  default: begin
                     if (!matched_ff) status_ff <= STAT_ABSENT;
                  end
               endcase
            end
            ST_DONE: begin
               rsp_victim_found <= 1'b0;
               rsp_victim_id    <= '0;
               rsp_victim_bytes <= '0;
               rsp_victim_place <= '0;
               rsp_victim_rank  <= '0;
               rsp_last_result  <= 1'b1;
               rsp_status       <= status_ff;
               rsp_entry_count  <= 6'(count_ff);
               rsp_total_bytes  <= total_ff;
               rsp_place_bytes  <= ps_cur;
               state_ff         <= ST_IDLE;
            end
            ST_SEARCH: begin
               if (cur_elig && (n_ff == '0)) cand_ff <= cand_ff + 1'b1;
               if (take) begin
                  best_idx_ff   <= idx_ff;
                  best_rank_ff  <= rank_ff[idx_ff];
                  best_stamp_ff <= stamp_ff[idx_ff];
                  best_key_ff   <= key_ff[idx_ff];
                  best_bytes_ff <= bytes_ff[idx_ff];
                  best_place_ff <= cur_place;
               end
               if (last_idx) begin
                  idx_ff           <= '0;
                  best_ok_ff       <= 1'b0;
                  rsp_victim_found <= fb_ok;
                  rsp_victim_id    <= fb_ok ? fb_key : '0;
                  rsp_victim_bytes <= fb_ok ? fb_bytes : '0;
                  rsp_victim_place <= fb_ok ? fb_place : '0;
                  rsp_victim_rank  <= fb_ok ? fb_rank : '0;
                  rsp_last_result  <= fin;
                  rsp_status       <= STAT_OK;
                  rsp_entry_count  <= 6'(count_ff);
                  rsp_total_bytes  <= total_ff;
                  rsp_place_bytes  <= ps_cur;
                  if (fb_ok) done_ff[fb_idx] <= 1'b1;
                  n_ff   <= n_nx;
                  sum_ff <= sum_nx;
                  if (fin) state_ff <= ST_IDLE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  if (take) best_ok_ff <= 1'b1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("entry count exceeds table size");
   a_victim_rank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_victim_found |-> rsp_victim_rank != 3'd0)
      else $error("rank 0 entry chosen as victim");
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_FULL) |-> rsp_entry_count == 6'(ENTRIES))
      else $error("full status with free slots");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request taken without going busy");
endmodule
`default_nettype wire
